// ===== rtl/core/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_GOTO  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  character;
		logic [6:0]  goto_x;
		logic [4:0]  goto_y;
		logic [10:0] cell_index;
	} cmd_item_t;

	typedef struct packed {
		logic [6:0]  cursor_x;
		logic [4:0]  cursor_y;
		logic [10:0] cursor_offset;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
		logic        scrolled;
	} res_item_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [7:0]  CHAR_BS          = 8'h08;
	localparam logic [7:0]  CHAR_LF          = 8'h0A;
	localparam logic [7:0]  CHAR_CR          = 8'h0D;
	localparam logic [7:0]  CHAR_BLANK       = 8'h20;
	localparam logic [7:0]  CHAR_PRINT_LAST  = 8'h7F;
	localparam logic [15:0] CELL_RESET       = 16'h0720;
	localparam logic [3:0]  TEXT_COLOUR_RST  = 4'd7;

endpackage

// ===== rtl/core/tcw_screen_ram.sv =====
// Screen cell store: one write port and one read port with registered read data.
module tcw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// The read data holds until the next read, so a result can wait on it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/text_console_writer_top.sv =====
// Text console writer top level: cursor control, sweeps and screen store.
//
//  Channel  Direction  Handshake              Payload
//  cmd      in         cmd_valid / cmd_ready  cmd (cmd_item_t)
//  res      out        res_valid / res_ready  res (res_item_t)
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is in work at a time. Clear screen sweeps the store through the one write port,
// and a put that scrolls runs a read-then-write copy through the store. After reset a
// clearing pass fills the store with 0x0720; cmd_ready is low meanwhile, cfg_ready is
// always high. A waiting result holds the next item in its last cycle.
module text_console_writer_top import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_item_t             cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_item_t             res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int NW         = AW + 1;
	localparam int CW         = $clog2(COLUMNS);
	localparam int RW         = $clog2(ROWS);

	localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
	localparam logic [AW-1:0] COL_STEP   = AW'(COLUMNS);
	localparam logic [NW-1:0] MOVE_COUNT = NW'(CELL_COUNT - COLUMNS);
	localparam logic [NW-1:0] CELL_LAST  = NW'(CELL_COUNT - 1);
	localparam logic [NW-1:0] CELL_END   = NW'(CELL_COUNT);

	localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOUR  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_ENABLE = CFG_IDX_W'(2);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_FILL,
		S_SCROLL,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [NW-1:0]   cnt_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [3:0]      text_q;
	logic [2:0]      back_q;
	logic            blink_q;
	logic            rd_ok_q;
	logic            scrolled_q;
	logic            res_valid_q;
	res_item_t       res_q;

	logic [7:0]      attr;
	logic [15:0]     blank;
	logic [AW-1:0]   pos;
	logic [7:0]      ch;
	logic            printable;
	logic [CW-1:0]   nx_col;
	logic [RW-1:0]   nx_row;
	logic            scroll_req;
	logic            put_we;
	logic [AW-1:0]   put_addr;
	logic [15:0]     put_data;
	logic [CW-1:0]   gx_sat;
	logic [RW-1:0]   gy_sat;
	logic            rd_in_range;
	logic            res_load;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [15:0]     mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	logic [15:0]     mem_rdata;

	assign attr        = {blink_q, back_q, text_q};
	assign blank       = {attr, CHAR_BLANK};
	assign pos         = AW'(col_q) + AW'(AW'(row_q) * COL_STEP);
	assign ch          = cmd.character;
	assign printable   = ch inside {[CHAR_BLANK:CHAR_PRINT_LAST]};
	assign gx_sat      = (9'(cmd.goto_x) > 9'(COLUMNS - 1)) ? COL_LAST : CW'(cmd.goto_x);
	assign gy_sat      = (8'(cmd.goto_y) > 8'(ROWS - 1)) ? ROW_LAST : RW'(cmd.goto_y);
	assign rd_in_range = 16'(cmd.cell_index) < 16'(CELL_COUNT);
	assign res_load    = (state_q == S_DONE) && (!res_valid_q || res_ready);

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

	// Cursor movement and the single cell write that a printable character or a backspace makes.
	always_comb begin
		nx_col     = col_q;
		nx_row     = row_q;
		scroll_req = 1'b0;
		put_we     = 1'b0;
		put_addr   = pos;
		put_data   = {attr, ch};
		if (ch == CHAR_CR) begin
			nx_col = '0;
		end else if (ch == CHAR_LF) begin
			nx_col = '0;
			if (row_q == ROW_LAST) begin
				scroll_req = 1'b1;
			end else begin
				nx_row = row_q + 1'b1;
			end
		end else if (ch == CHAR_BS) begin
			put_we   = 1'b1;
			put_data = blank;
			if (pos != '0) begin
				put_addr = pos - 1'b1;
			end
			if (col_q != '0) begin
				nx_col = col_q - 1'b1;
			end else if (row_q != '0) begin
				nx_row = row_q - 1'b1;
				nx_col = COL_LAST;
			end
		end else if (printable) begin
			put_we = 1'b1;
			if (col_q == COL_LAST) begin
				nx_col = '0;
				if (row_q == ROW_LAST) begin
					scroll_req = 1'b1;
				end else begin
					nx_row = row_q + 1'b1;
				end
			end else begin
				nx_col = col_q + 1'b1;
			end
		end
	end

	// Store port control. The scroll copy reads COLUMNS cells ahead of its write,
	// so the same cell is never read and written in one cycle.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(cnt_q);
		mem_wdata = blank;
		mem_re    = 1'b0;
		mem_raddr = AW'(cmd.cell_index);
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = CELL_RESET;
			end
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.command)
						CMD_PUT: begin
							mem_we    = put_we;
							mem_waddr = put_addr;
							mem_wdata = put_data;
						end
						CMD_READ: begin
							mem_re = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_FILL: begin
				mem_we = 1'b1;
			end
			S_SCROLL: begin
				mem_re    = (cnt_q < MOVE_COUNT);
				mem_raddr = AW'(cnt_q) + COL_STEP;
				mem_we    = (cnt_q != '0);
				mem_waddr = AW'(cnt_q - 1'b1);
				mem_wdata = (cnt_q <= MOVE_COUNT) ? mem_rdata : blank;
			end
			default: ;
		endcase
	end

	tcw_screen_ram #(
		.DEPTH (CELL_COUNT),
		.AW    (AW)
	) u_screen_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_q  <= TEXT_COLOUR_RST;
			back_q  <= '0;
			blink_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEXT_COLOUR:  text_q  <= cfg_data;
				REG_BACK_COLOUR:  back_q  <= cfg_data[2:0];
				REG_BLINK_ENABLE: blink_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			rd_ok_q     <= 1'b0;
			scrolled_q  <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) begin
				res_valid_q         <= 1'b1;
				res_q.cursor_x      <= 7'(col_q);
				res_q.cursor_y      <= 5'(row_q);
				res_q.cursor_offset <= 11'(pos);
				res_q.cell_char     <= rd_ok_q ? mem_rdata[7:0] : 8'd0;
				res_q.cell_attr     <= rd_ok_q ? mem_rdata[15:8] : 8'd0;
				res_q.scrolled      <= scrolled_q;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (cnt_q == CELL_LAST) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						rd_ok_q    <= (cmd.command == CMD_READ) && rd_in_range;
						scrolled_q <= (cmd.command == CMD_PUT) && scroll_req;
						cnt_q      <= '0;
						case (cmd.command)
							CMD_PUT: begin
								col_q   <= nx_col;
								row_q   <= nx_row;
								state_q <= scroll_req ? S_SCROLL : S_DONE;
							end
							CMD_CLEAR: begin
								col_q   <= '0;
								row_q   <= '0;
								state_q <= S_FILL;
							end
							CMD_GOTO: begin
								col_q   <= gx_sat;
								row_q   <= gy_sat;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CELL_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_SCROLL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CELL_END) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cmd_valid,
	input logic                  cmd_ready,
	input logic                  res_valid,
	input logic                  res_ready,
	input res_item_t             res,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// A stalled result keeps its transaction intact.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed or dropped while stalled");

	// Only one command is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted while another was in work");

	// A scroll always leaves the cursor at the start of the bottom row.
	a_scroll_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.scrolled |->
			res.cursor_x == 7'd0 && (ROWS > 32 || res.cursor_y == 5'(ROWS - 1)))
		else $error("scroll left the cursor off the bottom row start");

	// The reported offset matches the reported cursor.
	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && COLUMNS <= 128 && ROWS <= 32 |->
			res.cursor_offset == 11'(int'(res.cursor_x) + int'(res.cursor_y) * COLUMNS))
		else $error("cursor offset does not match cursor position");

	// A register write is always taken, and carries known index and data.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
		else $error("register write refused or carrying unknown bits");

endmodule

bind text_console_writer_top tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (.*);

// ===== verif/text_console_writer_top_tb.sv =====
// Self-checking testbench for the text console writer: cursor, screen store and colours.
`timescale 1ns / 1ps

module text_console_writer_top_tb;
	import tcw_pkg::*;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOUR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 2'd3;

	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_ITEMS     = 250;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int QUIET_LIMIT     = 20000;
	localparam int DRAIN_CYCLES    = 20;

	logic                  clk;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_ready;
	cmd_item_t             cmd;
	logic                  res_valid;
	logic                  res_ready;
	res_item_t             res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the console: screen, cursor and colour registers.
	logic [15:0] screen_shadow [0:CELL_COUNT-1];
	int unsigned col_shadow;
	int unsigned row_shadow;
	logic [3:0]  text_colour_shadow;
	logic [2:0]  back_colour_shadow;
	logic        blink_shadow;

	res_item_t   pending_console_results[$];
	int unsigned mismatch_count;
	int unsigned results_seen;
	int unsigned quiet_cycles;
	bit          idling_on;
	bit          hold_off_req;

	text_console_writer_top #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] current_attr();
		return {blink_shadow, back_colour_shadow, text_colour_shadow};
	endfunction

	function automatic logic [15:0] blank_cell();
		return {current_attr(), CHAR_BLANK};
	endfunction

	// Applies one command to the shadow console and returns the result it must produce.
	function automatic res_item_t advance_console(cmd_item_t item);
		res_item_t   r;
		int unsigned pos;
		logic        did_scroll;
		r = '0;
		did_scroll = 1'b0;
		case (item.command)
			CMD_PUT: begin
				if (item.character == CHAR_CR) begin
					col_shadow = 0;
				end else if (item.character == CHAR_LF) begin
					col_shadow = 0;
					row_shadow++;
				end else if (item.character == CHAR_BS) begin
					pos = col_shadow + row_shadow * COLUMNS;
					if (pos > 0)
						pos--;
					if (col_shadow > 0) begin
						col_shadow--;
					end else if (row_shadow > 0) begin
						row_shadow--;
						col_shadow = COLUMNS - 1;
					end
					if (pos < CELL_COUNT)
						screen_shadow[pos] = blank_cell();
				end else if (item.character >= CHAR_BLANK && item.character <= CHAR_PRINT_LAST) begin
					pos = col_shadow + row_shadow * COLUMNS;
					if (pos < CELL_COUNT)
						screen_shadow[pos] = {current_attr(), item.character};
					col_shadow++;
					if (col_shadow >= COLUMNS) begin
						col_shadow = 0;
						row_shadow++;
					end
				end
				// Leaving the bottom row moves every line up and blanks the last one.
				if (row_shadow >= ROWS) begin
					for (int i = 0; i < CELL_COUNT; i++)
						screen_shadow[i] = (i < CELL_COUNT - COLUMNS) ?
							screen_shadow[i + COLUMNS] : blank_cell();
					row_shadow = ROWS - 1;
					did_scroll = 1'b1;
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					screen_shadow[i] = blank_cell();
				col_shadow = 0;
				row_shadow = 0;
			end
			CMD_GOTO: begin
				col_shadow = (item.goto_x < COLUMNS) ? item.goto_x : COLUMNS - 1;
				row_shadow = (item.goto_y < ROWS) ? item.goto_y : ROWS - 1;
			end
			CMD_READ: begin
				if (item.cell_index < CELL_COUNT)
					{r.cell_attr, r.cell_char} = screen_shadow[item.cell_index];
			end
			default: ;
		endcase
		r.cursor_x      = 7'(col_shadow);
		r.cursor_y      = 5'(row_shadow);
		r.cursor_offset = 11'(col_shadow + row_shadow * COLUMNS);
		r.scrolled      = did_scroll;
		return r;
	endfunction

	// Fields that the command does not use still carry random bits.
	function automatic cmd_item_t random_item();
		cmd_item_t item;
		item.command    = cmd_t'($urandom_range(0, 3));
		item.character  = 8'($urandom);
		item.goto_x     = 7'($urandom);
		item.goto_y     = 5'($urandom);
		item.cell_index = 11'($urandom);
		return item;
	endfunction

	function automatic cmd_item_t put_item(logic [7:0] character);
		cmd_item_t item;
		item = random_item();
		item.command = CMD_PUT;
		item.character = character;
		return item;
	endfunction

	function automatic cmd_item_t goto_item(logic [6:0] x, logic [4:0] y);
		cmd_item_t item;
		item = random_item();
		item.command = CMD_GOTO;
		item.goto_x = x;
		item.goto_y = y;
		return item;
	endfunction

	function automatic cmd_item_t read_item(logic [10:0] index);
		cmd_item_t item;
		item = random_item();
		item.command = CMD_READ;
		item.cell_index = index;
		return item;
	endfunction

	function automatic cmd_item_t clear_item();
		cmd_item_t item;
		item = random_item();
		item.command = CMD_CLEAR;
		return item;
	endfunction

	task automatic note_mismatch(string msg);
		$display("[%0t] console check failed: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string field, logic [10:0] got, logic [10:0] want);
		if (got !== want)
			note_mismatch($sformatf("result %0d %s is %0d, should be %0d",
				results_seen, field, got, want));
	endtask

	// Offers one command, with a random gap in front while idling is on, and records its result on acceptance.
	task automatic issue_command(cmd_item_t item);
		int unsigned gap;
		gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
		@(negedge clk);
		if (gap != 0) begin
			cmd_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid = 1'b1;
		cmd = item;
		do @(posedge clk); while (!cmd_ready);
		pending_console_results.push_back(advance_console(item));
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_TEXT_COLOUR: text_colour_shadow = value;
			REG_BACK_COLOUR: back_colour_shadow = value[2:0];
			REG_BLINK:       blink_shadow = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_colours(logic [3:0] text, logic [2:0] back, logic blink);
		write_register(REG_TEXT_COLOUR, text);
		write_register(REG_BACK_COLOUR, {1'b0, back});
		write_register(REG_BLINK, {3'b000, blink});
	endtask

	// Every command returns a result, so the block is idle once none is pending.
	task automatic settle_console();
		@(negedge clk);
		cmd_valid = 1'b0;
		while (pending_console_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_power_on_screen();
		issue_command(read_item(11'd0));
		issue_command(read_item(11'(CELL_COUNT - 1)));
		issue_command(read_item(11'(CELL_COUNT)));
		issue_command(read_item(11'h7FF));
	endtask

	task automatic test_cursor_edges();
		issue_command(goto_item(7'h7F, 5'h1F));
		// Printing in the last cell wraps past the bottom row and scrolls.
		issue_command(put_item(8'h41));
		issue_command(read_item(11'(CELL_COUNT - COLUMNS - 1)));
		issue_command(read_item(11'(CELL_COUNT - 1)));
		issue_command(goto_item(7'(COLUMNS), 5'(ROWS)));
		issue_command(goto_item(7'd0, 5'd0));
	endtask

	task automatic test_control_bytes();
		issue_command(put_item(CHAR_BS));
		issue_command(put_item(CHAR_PRINT_LAST));
		issue_command(put_item(CHAR_CR));
		issue_command(put_item(CHAR_LF));
		// Backspace from column 0 goes to the end of the row above.
		issue_command(put_item(CHAR_BS));
		issue_command(put_item(8'h00));
		issue_command(put_item(8'h1F));
		issue_command(put_item(8'h80));
		issue_command(put_item(8'hFF));
		issue_command(put_item(CHAR_BLANK));
		issue_command(read_item(11'(COLUMNS - 1)));
	endtask

	task automatic test_clear_screen();
		issue_command(clear_item());
		issue_command(read_item(11'd0));
		issue_command(read_item(11'(CELL_COUNT - COLUMNS - 1)));
	endtask

	task automatic test_colour_settings();
		settle_console();
		write_colours(4'hF, 3'd7, 1'b1);
		issue_command(goto_item(7'd10, 5'd5));
		issue_command(put_item(8'h5A));
		issue_command(read_item(11'(5 * COLUMNS + 10)));
		issue_command(put_item(CHAR_BS));
		issue_command(read_item(11'(5 * COLUMNS + 10)));
		settle_console();
		write_colours(4'h0, 3'd0, 1'b0);
		issue_command(put_item(8'h61));
		issue_command(read_item(11'(5 * COLUMNS + 10)));
		settle_console();
		write_register(REG_UNUSED, 4'hF);
		issue_command(put_item(8'h62));
		issue_command(read_item(11'(5 * COLUMNS + 11)));
	endtask

	// The receiver stops for a long stretch while commands keep coming.
	task automatic test_back_pressure();
		settle_console();
		idling_on = 1'b0;
		hold_off_req = 1'b1;
		repeat (20)
			issue_command(put_item(8'($urandom_range(CHAR_BLANK, CHAR_PRINT_LAST))));
		idling_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		cmd_item_t   item;
		int unsigned pick;
		int unsigned here;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle_console();
			case (phase)
				0: write_colours(4'hF, 3'd7, 1'b1);
				1: write_colours(4'h0, 3'd0, 1'b0);
				default: write_colours(4'($urandom), 3'($urandom), 1'($urandom));
			endcase
			// The second phase is quiet, and the final phase runs without any idling.
			idling_on = (phase != 1 && phase != RANDOM_PHASES - 1);
			repeat (PHASE_ITEMS) begin
				item = random_item();
				pick = $urandom_range(0, 199);
				here = col_shadow + row_shadow * COLUMNS;
				if (pick < 110) begin
					item.command = CMD_PUT;
					item.character = 8'($urandom_range(CHAR_BLANK, CHAR_PRINT_LAST));
				end else if (pick < 116) begin
					item.command = CMD_PUT;
					item.character = CHAR_LF;
				end else if (pick < 124) begin
					item.command = CMD_PUT;
					item.character = CHAR_CR;
				end else if (pick < 134) begin
					item.command = CMD_PUT;
					item.character = CHAR_BS;
				end else if (pick < 142) begin
					item.command = CMD_PUT;
					item.character = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hFF))
						: 8'($urandom_range(8'h00, 8'h1F));
				end else if (pick < 170) begin
					item.command = CMD_READ;
					// Mostly read back what was just written near the cursor.
					if ($urandom_range(0, 2) != 0 && here > 5)
						item.cell_index = 11'(here - $urandom_range(1, 5));
				end else if (pick < 198) begin
					item.command = CMD_GOTO;
				end else begin
					item.command = CMD_CLEAR;
				end
				issue_command(item);
			end
		end
	endtask

	initial begin
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				res_ready = 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				res_ready = 1'b0;
				repeat ($urandom_range(1, 14) - 1) @(negedge clk);
			end else begin
				res_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_console_results.size() == 0) begin
				note_mismatch($sformatf("result %0d arrived with no command pending",
					results_seen));
			end else begin
				want = pending_console_results.pop_front();
				check_field("cursor_x", res.cursor_x, want.cursor_x);
				check_field("cursor_y", res.cursor_y, want.cursor_y);
				check_field("cursor_offset", res.cursor_offset, want.cursor_offset);
				check_field("cell_char", res.cell_char, want.cell_char);
				check_field("cell_attr", res.cell_attr, want.cell_attr);
				check_field("scrolled", res.scrolled, want.scrolled);
			end
			results_seen++;
		end
	end

	// Ends the run when no transaction has completed on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatch_count = 0;
		results_seen = 0;
		quiet_cycles = 0;
		idling_on = 1'b1;
		hold_off_req = 1'b0;
		for (int i = 0; i < CELL_COUNT; i++)
			screen_shadow[i] = CELL_RESET;
		col_shadow = 0;
		row_shadow = 0;
		text_colour_shadow = TEXT_COLOUR_RST;
		back_colour_shadow = 3'd0;
		blink_shadow = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_power_on_screen();
		test_cursor_edges();
		test_control_bytes();
		test_clear_screen();
		test_colour_settings();
		test_back_pressure();
		test_random_traffic();

		settle_console();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_console_results.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", pending_console_results.size()));
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
